@@ hw/rtl/adcpp_pkg.sv @@
// Shared types and constants for the ping-pong ADC sample buffer.
// Depends on nothing; imported by adcpp_store and adc_ping_pong_sample_buffer.
package adcpp_pkg;

	localparam int PERIOD_W = 20;
	localparam int ADC_W    = 12;
	localparam int BYTE_W   = 8;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_CLAIM = 3'd1,
		OP_READ  = 3'd2,
		OP_START = 3'd3,
		OP_STOP  = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic [ADC_W-1:0]  adc_value;
		logic [BYTE_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic              sample_taken;
		logic              buffer_completed;
		logic              ready_res;
		logic              claim_ok;
		logic [BYTE_W-1:0] read_data;
	} out_item_t;

	// Control between the capture logic and the sample store
	typedef struct packed {
		logic wr_en;
		logic wr_sel;
		logic rd_en;
		logic rd_sel;
	} st_ctl_t;

endpackage

@@ hw/rtl/adcpp_store.sv @@
// Two-bank sample store with one write and one registered read port.
// Per-bank fill counts stand in for a cleared memory. Uses adcpp_pkg.
module adcpp_store #(
	parameter int SAMPLES_PER_BUFFER = 256
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  adcpp_pkg::st_ctl_t                      ctl,
	input  logic [$clog2(SAMPLES_PER_BUFFER)-1:0]   wr_pos,
	input  logic [adcpp_pkg::BYTE_W-1:0]            wr_data,
	input  logic [$clog2(SAMPLES_PER_BUFFER)-1:0]   rd_pos,
	output logic [adcpp_pkg::BYTE_W-1:0]            rd_data
);
	import adcpp_pkg::*;

	localparam int PW    = $clog2(SAMPLES_PER_BUFFER);
	localparam int DEPTH = 2 << PW;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] data_q;
	logic              hit_q;
	logic [PW:0]       fill_q [2];

	// Writes always climb from position zero, so each bank holds a written prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else if (ctl.wr_en && ({1'b0, wr_pos} == fill_q[ctl.wr_sel])) begin
			fill_q[ctl.wr_sel] <= fill_q[ctl.wr_sel] + (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[{ctl.wr_sel, wr_pos}] <= wr_data;
		end
		if (ctl.rd_en) begin
			data_q <= mem[{ctl.rd_sel, rd_pos}];
			hit_q  <= ({1'b0, rd_pos} < fill_q[ctl.rd_sel]);
		end
	end

	// Unwritten entries read as zero
	assign rd_data = hit_q ? data_q : '0;

endmodule

@@ hw/rtl/adc_ping_pong_sample_buffer.sv @@
// Top level of the ping-pong ADC sample buffer: capture control, result path.
// Depends on adcpp_pkg and adcpp_store.
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_stall    in_data  (adcpp_pkg::in_item_t)
//   out       output      out_valid/out_stall  out_data (adcpp_pkg::out_item_t)
//   cfg       input       cfg_we               cfg_wdata (sample period)
//
// One transaction a cycle while in_stall is low; a result is presented after its
// acceptance has passed the result stage (with the store's registered read) and
// then the output register.
// State updates at the accepting edge, so back-to-back items see each other.
// Reset clears control state at once; the store reads as zero until written.
// A stalled output holds one result and one more item in flight; in_stall rises
// only when both are full and the output is stalled.
module adc_ping_pong_sample_buffer #(
	parameter int SAMPLES_PER_BUFFER = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [adcpp_pkg::PERIOD_W-1:0]     cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  adcpp_pkg::in_item_t                in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output adcpp_pkg::out_item_t               out_data
);
	import adcpp_pkg::*;

	localparam int PW = $clog2(SAMPLES_PER_BUFFER);

	logic [PERIOD_W-1:0] sample_period_q;
	logic                running_q;
	logic [PERIOD_W-1:0] elapsed_q;
	logic [PW-1:0]       wpos_q;
	logic                wsel_q;
	logic                ready_q;
	logic                latch_q;

	logic                in_acc;
	logic                s1_move;
	logic                valid_s1;
	logic                taken_s1, completed_s1, ready_s1, claim_s1, rd_s1;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W-1:0] elapsed_inc;
	logic                due;
	logic                wr_en, wr_last, claim_hit, rd_hit, idx_in_range;
	logic                running_d, wsel_d, ready_d, latch_d;
	logic [PERIOD_W-1:0] elapsed_d;
	logic [PW-1:0]       wpos_d;
	logic [PW+7:0]       idx_ext;
	st_ctl_t             st_ctl;
	logic [BYTE_W-1:0]   st_rd_data;

	assign s1_move  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_move;
	assign in_acc   = in_valid && !in_stall;

	assign period_eff   = (sample_period_q == '0) ? PERIOD_W'(1) : sample_period_q;
	assign elapsed_inc  = elapsed_q + PERIOD_W'(1);
	assign due          = (elapsed_inc >= period_eff);
	assign wr_last      = (wpos_q == PW'(SAMPLES_PER_BUFFER - 1));
	assign idx_ext      = {{PW{1'b0}}, in_data.read_index};
	assign idx_in_range = (int'(in_data.read_index) < SAMPLES_PER_BUFFER);

	always_comb begin
		running_d = running_q;
		elapsed_d = elapsed_q;
		wpos_d    = wpos_q;
		wsel_d    = wsel_q;
		ready_d   = ready_q;
		latch_d   = latch_q;
		wr_en     = 1'b0;
		claim_hit = 1'b0;
		rd_hit    = 1'b0;
		unique case (in_data.operation)
			OP_TICK: begin
				if (running_q) begin
					elapsed_d = elapsed_inc;
					if (due) begin
						elapsed_d = '0;
						wr_en     = 1'b1;
						if (wr_last) begin
							ready_d = 1'b1;
							wsel_d  = !wsel_q;
							wpos_d  = '0;
						end else begin
							wpos_d = wpos_q + PW'(1);
						end
					end
				end
			end
			OP_CLAIM: begin
				if (ready_q) begin
					latch_d   = !wsel_q;
					ready_d   = 1'b0;
					claim_hit = 1'b1;
				end
			end
			OP_READ: begin
				rd_hit = idx_in_range;
			end
			OP_START, OP_STOP: begin
				running_d = (in_data.operation == OP_START);
				elapsed_d = '0;
				wpos_d    = '0;
				wsel_d    = 1'b0;
				ready_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= PERIOD_W'(125);
		end else if (cfg_we) begin
			sample_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			elapsed_q <= '0;
			wpos_q    <= '0;
			wsel_q    <= 1'b0;
			ready_q   <= 1'b0;
			latch_q   <= 1'b0;
		end else if (in_acc) begin
			running_q <= running_d;
			elapsed_q <= elapsed_d;
			wpos_q    <= wpos_d;
			wsel_q    <= wsel_d;
			ready_q   <= ready_d;
			latch_q   <= latch_d;
		end
	end

	assign st_ctl = '{
		wr_en:  in_acc && wr_en,
		wr_sel: wsel_q,
		rd_en:  in_acc && rd_hit,
		rd_sel: latch_q
	};

	adcpp_store #(
		.SAMPLES_PER_BUFFER(SAMPLES_PER_BUFFER)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.wr_pos  (wpos_q),
		.wr_data (in_data.adc_value[ADC_W-1 -: BYTE_W]),
		.rd_pos  (idx_ext[PW-1:0]),
		.rd_data (st_rd_data)
	);

	// Result stage: flags wait here alongside the store's registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			taken_s1     <= wr_en;
			completed_s1 <= wr_en && wr_last;
			ready_s1     <= ready_d;
			claim_s1     <= claim_hit;
			rd_s1        <= rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			out_q.sample_taken     <= taken_s1;
			out_q.buffer_completed <= completed_s1;
			out_q.ready_res        <= ready_s1;
			out_q.claim_ok         <= claim_s1;
			out_q.read_data        <= rd_s1 ? st_rd_data : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_ready_from_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(in_acc && wr_en && wr_last))
		else $error("ready flag rose without a completed buffer");

	a_no_write_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wr_en) |-> running_q)
		else $error("sample written while stopped");

	a_claim_other_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && claim_hit) |=> (latch_q != wsel_q) && !ready_q)
		else $error("claim latched the bank being written");

	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |-> !in_acc)
		else $error("result stage overwritten while held");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wpos_q) < SAMPLES_PER_BUFFER)
		else $error("write position past end of buffer");
`endif

endmodule

@@ test/adc_ping_pong_sample_buffer_tb.sv @@
// Self-checking testbench for adc_ping_pong_sample_buffer: directed and random
// transactions checked against an in-bench capture predictor.
// Depends on adcpp_pkg and the adc_ping_pong_sample_buffer RTL.
module adc_ping_pong_sample_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import adcpp_pkg::*;

	localparam int SPB = 256;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam logic [PERIOD_W-1:0] PERIOD_AT_RESET = 20'd125;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [PERIOD_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	adc_ping_pong_sample_buffer #(
		.SAMPLES_PER_BUFFER(SPB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Capture state as the block should hold it
	logic [PERIOD_W-1:0] cap_period;
	logic                cap_running;
	logic [PERIOD_W-1:0] cap_elapsed;
	logic [7:0]          cap_wpos;
	logic                cap_wsel;
	logic                cap_ready;
	logic                cap_latch;
	logic [7:0]          cap_store [2*SPB];

	out_item_t pending_outcomes [$];
	out_item_t want;
	int mismatch_count = 0;
	int result_no = 0;
	bit steady_flow = 1'b0;

	function automatic void clear_capture();
		cap_elapsed = '0;
		cap_wpos = '0;
		cap_wsel = 1'b0;
		cap_ready = 1'b0;
	endfunction

	function automatic out_item_t step_capture(in_item_t it);
		out_item_t r;
		logic [PERIOD_W-1:0] per;
		r = '0;
		case (it.operation)
			OP_TICK: begin
				if (cap_running) begin
					per = (cap_period == '0) ? PERIOD_W'(1) : cap_period;
					cap_elapsed = cap_elapsed + PERIOD_W'(1);
					if (cap_elapsed >= per) begin
						cap_elapsed = '0;
						cap_store[{cap_wsel, cap_wpos}] = it.adc_value[ADC_W-1 -: BYTE_W];
						r.sample_taken = 1'b1;
						if (cap_wpos == 8'(SPB - 1)) begin
							// buffer full: flag it and swap halves
							cap_ready = 1'b1;
							cap_wsel = ~cap_wsel;
							cap_wpos = '0;
							r.buffer_completed = 1'b1;
						end else begin
							cap_wpos = cap_wpos + 8'(1);
						end
					end
				end
			end
			OP_CLAIM: begin
				if (cap_ready) begin
					cap_latch = ~cap_wsel;
					cap_ready = 1'b0;
					r.claim_ok = 1'b1;
				end
			end
			OP_READ: begin
				r.read_data = cap_store[{cap_latch, it.read_index}];
			end
			OP_START: begin
				clear_capture();
				cap_running = 1'b1;
			end
			OP_STOP: begin
				clear_capture();
				cap_running = 1'b0;
			end
			default: begin
			end
		endcase
		r.ready_res = cap_ready;
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("[%0t] mismatch on result %0d: %s", $realtime, result_no, msg);
		mismatch_count++;
	endtask

	// Hold the payload until the block takes it, then predict its outcome
	task automatic send_item(in_item_t it);
		while (!steady_flow && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_outcomes.push_back(step_capture(it));
	endtask

	task automatic send_op(logic [2:0] op, logic [ADC_W-1:0] adc, logic [BYTE_W-1:0] idx);
		in_item_t it;
		it.operation = op;
		it.adc_value = adc;
		it.read_index = idx;
		send_item(it);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_period(logic [PERIOD_W-1:0] p);
		wait_all_results();
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_period = p;
	endtask

	// Behavior out of reset: stopped block, empty claims, unused codes, ticks short of the period
	task automatic test_idle_ops();
		send_op(OP_READ, 12'h000, 8'h00);
		send_op(OP_READ, 12'hFFF, 8'hFF);
		send_op(OP_CLAIM, 12'h000, 8'h00);
		send_op(OP_TICK, 12'hFFF, 8'h00);
		for (logic [3:0] op = {1'b0, OP_SPARE_FIRST}; op <= {1'b0, OP_SPARE_LAST}; op++) begin
			send_op(op[2:0], 12'hFFF, 8'hFF);
		end
		send_op(OP_STOP, 12'h000, 8'h00);
		send_op(OP_START, 12'h000, 8'h00);
		send_op(OP_TICK, 12'h800, 8'h00);
		send_op(OP_TICK, 12'h7FF, 8'h00);
		send_op(OP_STOP, 12'h000, 8'h00);
	endtask

	// Zero period samples every tick; the widest period never fires here
	task automatic test_period_limits();
		write_period('0);
		send_op(OP_START, 12'h000, 8'h00);
		send_op(OP_TICK, 12'hFFF, 8'h00);
		send_op(OP_TICK, 12'h000, 8'h00);
		send_op(OP_TICK, 12'h5A5, 8'h00);
		send_op(OP_READ, 12'h000, 8'h00);
		send_op(OP_READ, 12'h000, 8'h01);
		send_op(OP_READ, 12'h000, 8'h02);
		send_op(OP_STOP, 12'h000, 8'h00);
		write_period(20'hFFFFF);
		send_op(OP_START, 12'h000, 8'h00);
		send_op(OP_TICK, 12'hABC, 8'h00);
		send_op(OP_TICK, 12'h123, 8'h00);
		send_op(OP_READ, 12'h000, 8'hFF);
		write_period(20'd1000000);
	endtask

	// Mostly running capture with claims and reads mixed in, across periods
	task automatic test_random_capture();
		logic [PERIOD_W-1:0] periods [6] = '{20'd1, 20'd2, 20'd0, 20'd3, 20'd1000000, 20'd1};
		int counts [6] = '{700, 300, 300, 150, 100, 150};
		int unsigned pick;
		logic [2:0] op;
		for (int ph = 0; ph < 6; ph++) begin
			write_period(periods[ph]);
			send_op(OP_START, 12'($urandom_range(4095)), 8'($urandom_range(255)));
			for (int n = 0; n < counts[ph]; n++) begin
				steady_flow = (ph == 0 && n >= 200 && n < 500);
				pick = $urandom_range(99);
				if (!cap_running && pick < 40)
					op = OP_START;
				else if (pick < 72)
					op = OP_TICK;
				else if (pick < 82)
					op = OP_CLAIM;
				else if (pick < 94)
					op = OP_READ;
				else if (pick < 95)
					op = OP_START;
				else if (pick < 96)
					op = OP_STOP;
				else
					op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
				send_op(op, 12'($urandom_range(4095)), 8'($urandom_range(255)));
			end
		end
		steady_flow = 1'b0;
	endtask

	always @(posedge clk) begin
		out_stall <= !steady_flow && ($urandom_range(99) < 28);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("result with no transaction waiting for it");
			end else begin
				want = pending_outcomes.pop_front();
				if (out_data.sample_taken !== want.sample_taken)
					flag_mismatch($sformatf("sample_taken %b, want %b",
						out_data.sample_taken, want.sample_taken));
				if (out_data.buffer_completed !== want.buffer_completed)
					flag_mismatch($sformatf("buffer_completed %b, want %b",
						out_data.buffer_completed, want.buffer_completed));
				if (out_data.ready_res !== want.ready_res)
					flag_mismatch($sformatf("ready_res %b, want %b",
						out_data.ready_res, want.ready_res));
				if (out_data.claim_ok !== want.claim_ok)
					flag_mismatch($sformatf("claim_ok %b, want %b",
						out_data.claim_ok, want.claim_ok));
				if (out_data.read_data !== want.read_data)
					flag_mismatch($sformatf("read_data %h, want %h",
						out_data.read_data, want.read_data));
			end
			result_no++;
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		cap_period = PERIOD_AT_RESET;
		cap_running = 1'b0;
		cap_latch = 1'b0;
		clear_capture();
		foreach (cap_store[i]) cap_store[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ops();
		test_period_limits();
		test_random_capture();
		wait_all_results();
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
